>>> design/bced_pkg.sv
// Shared types and constants for the button click event detector.
// No dependencies; used by button_click_event_detector_unit and its testbench.
package bced_pkg;

	localparam int NumButtons = 8;
	localparam int IdxW       = 3;
	localparam int AddrW      = $clog2(NumButtons);
	localparam int TimeW      = 16;
	localparam int CfgW       = 16;

	// Register indexes on the configuration port
	localparam logic [2:0] RegActiveLevels = 3'd0;
	localparam logic [2:0] RegLongPress    = 3'd1;
	localparam logic [2:0] RegDoubleClick  = 3'd2;
	localparam logic [2:0] RegDebounce     = 3'd3;
	localparam logic [2:0] RegTick         = 3'd4;

	// Register reset values
	localparam logic [7:0]       ActiveLevelsRst = 8'd0;
	localparam logic [TimeW-1:0] LongPressRst    = 16'd5000;
	localparam logic [TimeW-1:0] DoubleClickRst  = 16'd500;
	localparam logic [TimeW-1:0] DebounceRst     = 16'd50;
	localparam logic [7:0]       TickRst         = 8'd10;

	typedef enum logic [1:0] {
		PhReleased = 2'd0,
		PhPressed  = 2'd1,
		PhHolding  = 2'd2,
		PhLong     = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		EvNone   = 2'd0,
		EvShort  = 2'd1,
		EvLong   = 2'd2,
		EvDouble = 2'd3
	} event_t;

	// One button's state as kept in the state memory
	typedef struct packed {
		phase_t           phase;
		logic [TimeW-1:0] press_time;
		logic [TimeW-1:0] release_time;
		logic [1:0]       clicks;
	} entry_t;

	// Saturating timer advance
	function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] t,
			input logic [7:0] d);
		logic [TimeW:0] s;
		s = {1'b0, t} + {{(TimeW-7){1'b0}}, d};
		sat_add = s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
	endfunction

endpackage

>>> design/button_click_event_detector_unit.sv
// Button click event detector: per-button debounce, long press and double click.
// Depends on bced_pkg (types, register indexes, reset values, sat_add).
//
// Usage
//   Input channel (in_valid/in_ready): one tick sample per transaction, a button
//   index and the raw pin level of that button. Output channel (out_valid/
//   out_ready): exactly one result per sample, the echoed button id and an event
//   code (none, short press, long press, double click), in input order.
//   Configuration: cfg_we writes cfg_data into the register at cfg_index
//   (active levels, long press ms, double click ms, debounce ms, tick ms).
//   Write only while no sample is in flight.
// Pipeline
//   An accepted sample enters the state-update stage with its state memory entry.
//   When that stage advances, the result is computed, the entry written back and
//   the result registered on the output. One sample per cycle is taken unless
//   the output stalls; the state memory has one read and one write port, and a
//   sample after one on the same button gets the freshly written entry by bypass.
// Reset
//   arst_n clears the pipeline, the output register, the registers to their
//   defaults and a valid bit per memory entry; an entry not yet written reads as
//   released with all timers and the click count at zero. No clearing pass.
// Stall
//   When out_ready is low with a result waiting, one more sample is held in the
//   state-update stage and the input stalls after that; nothing is lost.
module button_click_event_detector_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  button_index,
	input  logic        level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  button_id,
	output logic [1:0]  event_res
);

	// Configuration registers
	logic [7:0]                  active_levels_q;
	logic [bced_pkg::TimeW-1:0]  long_press_q;
	logic [bced_pkg::TimeW-1:0]  double_click_q;
	logic [bced_pkg::TimeW-1:0]  debounce_q;
	logic [7:0]                  tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_levels_q <= bced_pkg::ActiveLevelsRst;
			long_press_q    <= bced_pkg::LongPressRst;
			double_click_q  <= bced_pkg::DoubleClickRst;
			debounce_q      <= bced_pkg::DebounceRst;
			tick_q          <= bced_pkg::TickRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bced_pkg::RegActiveLevels: active_levels_q <= cfg_data[7:0];
				bced_pkg::RegLongPress:    long_press_q    <= cfg_data;
				bced_pkg::RegDoubleClick:  double_click_q  <= cfg_data;
				bced_pkg::RegDebounce:     debounce_q      <= cfg_data;
				bced_pkg::RegTick:         tick_q          <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Pipeline control
	logic s1_valid_q;
	logic out_valid_q;
	logic s1_adv;
	logic in_acc;

	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_acc   = in_valid && in_ready;

	// Stage 1 payload
	logic [bced_pkg::IdxW-1:0] idx_s1;
	logic                      level_s1;
	logic                      byp_s1;
	logic                      vld_s1;
	bced_pkg::entry_t          rd_s1;

	// State memory, write-back register and entry valid bits
	bced_pkg::entry_t           mem [bced_pkg::NumButtons];
	logic [bced_pkg::NumButtons-1:0] ent_vld_q;
	bced_pkg::entry_t           wb_data_q;
	logic [bced_pkg::IdxW-1:0]  wb_idx_q;

	logic             in_range_in;
	logic             in_range_s1;
	logic             mem_we;
	bced_pkg::entry_t nxt;
	bced_pkg::event_t ev;

	assign in_range_in = {1'b0, button_index} < (bced_pkg::IdxW+1)'(bced_pkg::NumButtons);
	assign in_range_s1 = {1'b0, idx_s1} < (bced_pkg::IdxW+1)'(bced_pkg::NumButtons);
	assign mem_we      = s1_adv && in_range_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_s1[bced_pkg::AddrW-1:0]] <= nxt;
		end
		if (in_acc && in_range_in) begin
			rd_s1 <= mem[button_index[bced_pkg::AddrW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (mem_we) begin
			ent_vld_q[idx_s1[bced_pkg::AddrW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wb_data_q <= nxt;
			wb_idx_q  <= idx_s1;
		end
	end

	// Accept a sample: capture payload, entry valid bit and the bypass flag
	// for a write-back to the same button at this very edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_s1   <= button_index;
			level_s1 <= level;
			byp_s1   <= mem_we && (idx_s1 == button_index);
			vld_s1   <= in_range_in && ent_vld_q[button_index[bced_pkg::AddrW-1:0]];
		end
	end

	// Current entry: bypass first, then memory, else the reset entry
	bced_pkg::entry_t cur;
	always_comb begin
		if (byp_s1) begin
			cur = wb_data_q;
		end else if (vld_s1) begin
			cur = rd_s1;
		end else begin
			cur = '0;
		end
	end

	// Per-button state update
	logic                       act;
	logic [bced_pkg::TimeW-1:0] pt_inc;
	logic [bced_pkg::TimeW-1:0] rt_inc;
	logic [1:0]                 clk_inc;

	assign act     = (level_s1 == active_levels_q[idx_s1]);
	assign pt_inc  = bced_pkg::sat_add(cur.press_time, tick_q);
	assign rt_inc  = bced_pkg::sat_add(cur.release_time, tick_q);
	assign clk_inc = cur.clicks + 2'd1;

	always_comb begin
		nxt = cur;
		ev  = bced_pkg::EvNone;
		unique case (cur.phase)
			bced_pkg::PhReleased: begin
				if (act) begin
					nxt.phase      = bced_pkg::PhPressed;
					nxt.press_time = '0;
				end else if (cur.clicks == 2'd1) begin
					nxt.release_time = rt_inc;
					if (rt_inc >= double_click_q) begin
						ev               = bced_pkg::EvShort;
						nxt.clicks       = '0;
						nxt.release_time = '0;
					end
				end
			end
			bced_pkg::PhPressed: begin
				if (act) begin
					nxt.press_time = pt_inc;
					if (pt_inc >= debounce_q) begin
						nxt.phase = bced_pkg::PhHolding;
					end
				end else begin
					nxt.phase      = bced_pkg::PhReleased;
					nxt.press_time = '0;
				end
			end
			bced_pkg::PhHolding: begin
				if (act) begin
					nxt.press_time = pt_inc;
					if (pt_inc >= long_press_q) begin
						ev         = bced_pkg::EvLong;
						nxt.phase  = bced_pkg::PhLong;
						nxt.clicks = '0;
					end
				end else begin
					// count a click only for a hold between debounce and long press
					if (cur.press_time >= debounce_q && cur.press_time < long_press_q) begin
						nxt.clicks       = clk_inc;
						nxt.release_time = '0;
						if (clk_inc >= 2'd2) begin
							ev         = bced_pkg::EvDouble;
							nxt.clicks = '0;
						end
					end
					nxt.phase      = bced_pkg::PhReleased;
					nxt.press_time = '0;
				end
			end
			bced_pkg::PhLong: begin
				if (!act) begin
					nxt.phase      = bced_pkg::PhReleased;
					nxt.press_time = '0;
				end
			end
			default: ;
		endcase
		if (!in_range_s1) begin
			ev = bced_pkg::EvNone;
		end
	end

	// Output register
	logic [2:0] button_id_q;
	logic [1:0] event_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			button_id_q <= idx_s1;
			event_res_q <= ev;
		end
	end

	assign out_valid = out_valid_q;
	assign button_id = button_id_q;
	assign event_res = event_res_q;

	// Assertions
	a_byp_same_button: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && byp_s1 |-> wb_idx_q == idx_s1)
		else $error("bypass taken for a different button");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(idx_s1) && $stable(level_s1))
		else $error("stalled sample lost in state-update stage");

	a_long_phase: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && ev == bced_pkg::EvLong |-> nxt.phase == bced_pkg::PhLong)
		else $error("long press event without long-held phase");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> s1_valid_q)
		else $error("accepted sample did not enter state-update stage");

endmodule

>>> tb/sv/button_click_event_detector_unit_tb.sv
// Self-checking testbench for button_click_event_detector_unit.
// Depends on bced_pkg for the event codes, phase encoding and register indexes.
// Drives tick samples through a valid/ready driver, predicts each event and checks the output.
module button_click_event_detector_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HalfPeriod = 4;
	localparam int CycleLimit = 400000;
	localparam int IdlePct    = 31;

	typedef struct {
		logic [2:0] idx;
		logic       lvl;
	} sample_t;

	typedef struct {
		logic [2:0]       id;
		bced_pkg::event_t ev;
	} due_t;

	// DUT inputs start at known values
	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_we       = 1'b0;
	logic [2:0]  cfg_index    = bced_pkg::RegActiveLevels;
	logic [15:0] cfg_data     = '0;
	logic        in_valid     = 1'b0;
	logic [2:0]  button_index = '0;
	logic        level        = 1'b0;
	logic        out_ready    = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [2:0]  button_id;
	logic [1:0]  event_res;

	// Register copy used by the predictor and by the gesture generator
	logic [7:0]  cur_active   = bced_pkg::ActiveLevelsRst;
	logic [15:0] cur_long     = bced_pkg::LongPressRst;
	logic [15:0] cur_double   = bced_pkg::DoubleClickRst;
	logic [15:0] cur_debounce = bced_pkg::DebounceRst;
	logic [7:0]  cur_tick     = bced_pkg::TickRst;

	// Per-button state copy, cleared like the block after reset
	bced_pkg::phase_t btn_phase   [bced_pkg::NumButtons] = '{default: bced_pkg::PhReleased};
	logic [15:0]      btn_press   [bced_pkg::NumButtons] = '{default: '0};
	logic [15:0]      btn_release [bced_pkg::NumButtons] = '{default: '0};
	logic [1:0]       btn_clicks  [bced_pkg::NumButtons] = '{default: '0};

	sample_t samples_q[$];    // tick samples waiting for the driver
	due_t    events_due[$];   // predicted events, oldest first
	sample_t cur_sample;
	due_t    next_due;
	due_t    got_due;

	logic in_fire = 1'b0;
	int   idle_pct = IdlePct;
	int   rx_hold_asks = 0;
	int   rx_hold_done = 0;
	int   rx_hold_left = 0;
	int   queued_count = 0;
	int   cycle_count = 0;
	int   errors = 0;
	int   samples_taken = 0;
	int   results_seen = 0;
	int   settings_used = 0;
	int   n_short = 0;
	int   n_long = 0;
	int   n_double = 0;

	button_click_event_detector_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.button_index (button_index),
		.level        (level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.button_id    (button_id),
		.event_res    (event_res)
	);

	always #HalfPeriod clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Timeout after %0d cycles, %0d events still due", cycle_count,
				events_due.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Timer advance by one tick, pinned at the top of the 16-bit range
	function automatic logic [15:0] tick_add(logic [15:0] t);
		logic [16:0] s;
		s = {1'b0, t} + {9'd0, cur_tick};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	// Apply one tick sample to the button's state copy and return the event it raises
	function automatic bced_pkg::event_t advance_button(logic [2:0] b, logic lvl);
		bced_pkg::event_t ev;
		logic             act;
		ev  = bced_pkg::EvNone;
		act = (lvl == cur_active[b]);
		case (btn_phase[b])
			bced_pkg::PhReleased: begin
				if (act) begin
					btn_phase[b] = bced_pkg::PhPressed;
					btn_press[b] = '0;
				end else if (btn_clicks[b] == 2'd1) begin
					// a click is pending: run the double-click window
					btn_release[b] = tick_add(btn_release[b]);
					if (btn_release[b] >= cur_double) begin
						ev = bced_pkg::EvShort;
						btn_clicks[b] = '0;
						btn_release[b] = '0;
					end
				end
			end
			bced_pkg::PhPressed: begin
				if (act) begin
					btn_press[b] = tick_add(btn_press[b]);
					if (btn_press[b] >= cur_debounce)
						btn_phase[b] = bced_pkg::PhHolding;
				end else begin
					btn_phase[b] = bced_pkg::PhReleased;
					btn_press[b] = '0;
				end
			end
			bced_pkg::PhHolding: begin
				if (act) begin
					btn_press[b] = tick_add(btn_press[b]);
					if (btn_press[b] >= cur_long) begin
						ev = bced_pkg::EvLong;
						btn_phase[b] = bced_pkg::PhLong;
						btn_clicks[b] = '0;
					end
				end else begin
					// count a click only if the hold still lies between the two thresholds
					if (btn_press[b] >= cur_debounce && btn_press[b] < cur_long) begin
						btn_clicks[b] = btn_clicks[b] + 2'd1;
						btn_release[b] = '0;
						if (btn_clicks[b] >= 2'd2) begin
							ev = bced_pkg::EvDouble;
							btn_clicks[b] = '0;
						end
					end
					btn_phase[b] = bced_pkg::PhReleased;
					btn_press[b] = '0;
				end
			end
			default: begin
				if (!act) begin
					btn_phase[b] = bced_pkg::PhReleased;
					btn_press[b] = '0;
				end
			end
		endcase
		return ev;
	endfunction

	// Input side: predict at the edge where a transaction is accepted
	always @(posedge clk) begin
		in_fire <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			next_due.id = button_index;
			next_due.ev = advance_button(button_index, level);
			events_due.push_back(next_due);
			samples_taken++;
		end
	end

	// Driver: hold the payload until accepted, then offer the next sample or idle
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (samples_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				cur_sample = samples_q.pop_front();
				in_valid <= 1'b1;
				button_index <= cur_sample.idx;
				level <= cur_sample.lvl;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is asked for
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
			out_ready <= 1'b0;
		end else if (rx_hold_asks != rx_hold_done) begin
			rx_hold_done <= rx_hold_done + 1;
			rx_hold_left <= 150;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(99) >= idle_pct);
		end
	end

	// Output side: compare each result with the oldest predicted event
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (events_due.size() == 0) begin
				$error("unexpected result: button_id %0d event_res %0d", button_id, event_res);
				errors++;
			end else begin
				got_due = events_due.pop_front();
				if (button_id !== got_due.id) begin
					$error("button_id: expected %0d, got %0d", got_due.id, button_id);
					errors++;
				end
				if (event_res !== got_due.ev) begin
					$error("event_res: expected %0d, got %0d", got_due.ev, event_res);
					errors++;
				end
				case (got_due.ev)
					bced_pkg::EvShort:  n_short++;
					bced_pkg::EvLong:   n_long++;
					bced_pkg::EvDouble: n_double++;
					default:            ;
				endcase
			end
		end
	end

	function automatic int ticks_to(int unsigned ms);
		int unsigned step;
		int n;
		step = (cur_tick == 0) ? 1 : cur_tick;
		n = (ms + step - 1) / step;
		return (n > 40) ? 40 : n;
	endfunction

	task automatic add_sample(logic [2:0] b, logic lvl);
		cur_sample.idx = b;
		cur_sample.lvl = lvl;
		samples_q.push_back(cur_sample);
		queued_count++;
	endtask

	// Queue n samples of one button, either pressed or released
	task automatic add_run(logic [2:0] b, bit pressed, int n);
		repeat (n) add_sample(b, pressed ? cur_active[b] : !cur_active[b]);
	endtask

	// Write one register at the next edge and track it in the predictor's copy
	task automatic set_reg(logic [2:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			bced_pkg::RegActiveLevels: cur_active = value[7:0];
			bced_pkg::RegLongPress:    cur_long = value;
			bced_pkg::RegDoubleClick:  cur_double = value;
			bced_pkg::RegDebounce:     cur_debounce = value;
			bced_pkg::RegTick:         cur_tick = value[7:0];
			default:                   ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(logic [7:0] al, int lp, int dc, int db, int tk);
		set_reg(bced_pkg::RegActiveLevels, {8'd0, al});
		set_reg(bced_pkg::RegLongPress, lp[15:0]);
		set_reg(bced_pkg::RegDoubleClick, dc[15:0]);
		set_reg(bced_pkg::RegDebounce, db[15:0]);
		set_reg(bced_pkg::RegTick, tk[15:0]);
		settings_used++;
	endtask

	// Wait until the driver is drained and every predicted event has come back
	task automatic wait_idle();
		while (samples_q.size() != 0 || in_valid || events_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One random gesture on one button, sized around the current thresholds
	task automatic queue_gesture();
		logic [2:0] b;
		int dt, lt, wt, kind;
		b  = 3'($urandom_range(7));
		dt = ticks_to(cur_debounce);
		if (dt < 1)
			dt = 1;
		lt = ticks_to(cur_long);
		if (lt < dt)
			lt = dt;
		wt = ticks_to(cur_double);
		kind = $urandom_range(9);
		case (kind)
			0, 1, 2: begin
				// single click, then a release gap on either side of the window
				add_run(b, 1'b1, 1 + $urandom_range(lt, dt));
				add_run(b, 1'b0, $urandom_range(wt + 2, 1));
			end
			3, 4, 5: begin
				// two clicks, the second mostly inside the window
				add_run(b, 1'b1, 1 + $urandom_range(lt, dt));
				add_run(b, 1'b0, $urandom_range(wt, 1));
				add_run(b, 1'b1, 1 + $urandom_range(lt, dt));
				add_run(b, 1'b0, $urandom_range(2, 1));
			end
			6: begin
				add_run(b, 1'b1, 2 + lt + $urandom_range(2));
				add_run(b, 1'b0, 1 + $urandom_range(2));
			end
			7: begin
				// bounce shorter than the debounce time
				add_run(b, 1'b1, $urandom_range(dt, 1));
				add_run(b, 1'b0, 1);
			end
			default: begin
				repeat ($urandom_range(6, 1))
					add_sample(3'($urandom_range(7)), 1'($urandom_range(1)));
			end
		endcase
	endtask

	initial begin
		logic [7:0] al;
		int tk, db, lp, dc;

		// Hold reset, then release it away from the rising edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, small thresholds: a click on button 0, a double click on 7, a long press on 3
		apply_setting(8'hA5, 40, 30, 20, 10);
		add_run(3'd0, 1'b1, 3);
		add_run(3'd0, 1'b0, 3);
		add_run(3'd7, 1'b1, 3);
		add_run(3'd7, 1'b0, 1);
		add_run(3'd7, 1'b1, 3);
		add_run(3'd7, 1'b0, 1);
		add_run(3'd3, 1'b1, 5);
		add_run(3'd3, 1'b0, 1);
		// leave buttons 5 and 6 in the holding phase for the register change below
		add_run(3'd5, 1'b1, 3);
		add_run(3'd6, 1'b1, 4);
		wait_idle();

		// Move the thresholds mid-press: one release falls below debounce,
		// the other at or above the long-press time; neither counts a click
		apply_setting(8'hA5, 25, 30, 200, 10);
		add_run(3'd5, 1'b0, 1);
		add_run(3'd6, 1'b0, 2);
		wait_idle();

		// Saturate press_time: the hold only reaches debounce and long press at the ceiling
		apply_setting(8'hA5, 65535, 65535, 65535, 255);
		add_run(3'd1, 1'b1, 262);
		add_run(3'd1, 1'b0, 1);
		wait_idle();

		// Saturate release_time: the short press lands only when the window timer is pinned
		apply_setting(8'hA5, 65535, 65535, 0, 255);
		add_run(3'd2, 1'b1, 3);
		add_run(3'd2, 1'b0, 261);
		wait_idle();

		// Random phases; button state carries over from one setting to the next
		for (int k = 0; k < 8; k++) begin
			al = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom_range(255));
			tk = (k == 2) ? 1 : (k == 5) ? 0 : (k == 7) ? 255 : $urandom_range(255, 1);
			db = (k == 3 || k == 5) ? 0 : tk * $urandom_range(4);
			lp = (k == 4) ? 0 : (k == 5) ? $urandom_range(100, 1) : db + tk * $urandom_range(12, 1);
			dc = (k == 6) ? 0 : (k == 5) ? $urandom_range(500, 1) : tk * $urandom_range(10);
			apply_setting(al, lp, dc, db, tk);
			idle_pct = (k == 1) ? 0 : IdlePct;
			queued_count = 0;
			while (queued_count < 45)
				queue_gesture();
			// stall the receiver long enough for the block to back up into its input
			if (k == 0)
				rx_hold_asks++;
			// pause the sender until every result of the first half is back
			if (k == 2)
				wait_idle();
			while (queued_count < 90)
				queue_gesture();
			wait_idle();
		end

		repeat (8) @(posedge clk);
		$display("Checked %0d tick samples and %0d results over %0d register settings",
			samples_taken, results_seen, settings_used);
		$display("Events seen: %0d short, %0d long, %0d double; %0d mismatches",
			n_short, n_long, n_double, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
design/bced_pkg.sv
design/button_click_event_detector_unit.sv
tb/sv/button_click_event_detector_unit_tb.sv
